FILE: rtl/uv_sphere_vertex_generator_unit_assert.svh
// ----------------------------------------------------------------------------
// UV sphere vertex generator assertion macros
// Concurrent checks on the rising edge of clock, muted while reset is high.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_VERTEX_GENERATOR_UNIT_ASSERT_SVH
`define UV_SPHERE_VERTEX_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define UVS_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("uv sphere vertex generator: same-cycle check failed");

// next-cycle implication
`define UVS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("uv sphere vertex generator: next-cycle check failed");

`endif

FILE: rtl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// Types, constants and build-time sine, cosine and texture tables for the
// UV sphere vertex generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

   localparam int SUBDIVISIONS = 16;
   localparam int NUM_ANG      = 2 * SUBDIVISIONS + 1;
   localparam int IDX_W        = $clog2(SUBDIVISIONS + 1);
   localparam int ANG_W        = $clog2(NUM_ANG);

   localparam int LAT_W   = 4;
   localparam int LON_W   = 4;
   localparam int COORD_W = 24;
   localparam int TEX_W   = 17;
   localparam int REG_W   = 16;
   localparam int CSR_IDX_W = 2;

   localparam longint unsigned ONE_Q30     = 64'd1 << 30;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   localparam logic [REG_W-1:0] RADIUS_RESET = 16'd2048;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RADIUS,
      REG_CENTER_X,
      REG_CENTER_Y,
      REG_CENTER_Z
   } csr_reg_type;

   typedef enum logic [2:0] {
      CORNER_A,
      CORNER_B,
      CORNER_C,
      CORNER_C2,
      CORNER_B2,
      CORNER_D
   } corner_type;

   typedef struct packed {
      logic signed [31:0] s;
      logic signed [31:0] c;
   } sc_type;

   typedef sc_type [NUM_ANG-1:0] trig_tab_type;
   typedef logic [SUBDIVISIONS:0][TEX_W-1:0] tex_tab_type;

   // sin and cos of k*pi/S in Q1.30 for 0 <= k <= 2S
   function automatic trig_tab_type build_trig_tab();
      trig_tab_type    tab;
      longint unsigned two, quad, rem, m, x, x2, t, ps, pc;
      logic            swap;
      longint          a, b;
      int              k;
      tab = '0;
      for (k = 0; k < NUM_ANG; k++) begin
         two  = 2 * k;
         quad = (two / SUBDIVISIONS) & 3;
         rem  = two % SUBDIVISIONS;
         swap = (2 * rem) > SUBDIVISIONS;
         m    = swap ? SUBDIVISIONS - rem : rem;
         x    = (m * HALF_PI_Q30 + SUBDIVISIONS / 2) / SUBDIVISIONS;
         x2   = (x * x) >> 30;

         t  = ONE_Q30 - x2 / 72;
         t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
         t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
         t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
         ps = (x * t) >> 30;

         t  = ONE_Q30 - x2 / 90;
         t  = ONE_Q30 - ((x2 * t) >> 30) / 56;
         t  = ONE_Q30 - ((x2 * t) >> 30) / 30;
         t  = ONE_Q30 - ((x2 * t) >> 30) / 12;
         pc = ONE_Q30 - ((x2 * t) >> 30) / 2;

         a = swap ? longint'(pc) : longint'(ps);
         b = swap ? longint'(ps) : longint'(pc);
         case (quad)
            0: begin
               tab[k].s = 32'(a);
               tab[k].c = 32'(b);
            end
            1: begin
               tab[k].s = 32'(b);
               tab[k].c = 32'(-a);
            end
            2: begin
               tab[k].s = 32'(-a);
               tab[k].c = 32'(-b);
            end
            default: begin
               tab[k].s = 32'(-b);
               tab[k].c = 32'(a);
            end
         endcase
      end
      return tab;
   endfunction

   // round(j * 65536 / S), ties up
   function automatic tex_tab_type build_tex_tab();
      tex_tab_type tab;
      int          j;
      tab = '0;
      for (j = 0; j <= SUBDIVISIONS; j++) begin
         tab[j] = TEX_W'((longint'(j) * 65536 + SUBDIVISIONS / 2) / SUBDIVISIONS);
      end
      return tab;
   endfunction

   localparam trig_tab_type TRIG_TAB = build_trig_tab();
   localparam tex_tab_type  TEX_TAB  = build_tex_tab();

   // shift right by 30, ties away from zero
   function automatic logic signed [63:0] round_sh30(input logic signed [63:0] v);
      logic [63:0] mag;
      mag = v[63] ? 64'(-v) : 64'(v);
      mag = (mag + (64'd1 << 29)) >> 30;
      return v[63] ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic logic signed [COORD_W-1:0] sat24(input logic signed [63:0] v);
      logic signed [63:0] hi, lo;
      hi = 64'sd8388607;
      lo = -64'sd8388608;
      if (v > hi) begin
         return COORD_W'(hi);
      end else if (v < lo) begin
         return COORD_W'(lo);
      end
      return COORD_W'(v);
   endfunction

endpackage

FILE: rtl/uvs_if.sv
// ----------------------------------------------------------------------------
// uvs_req_if / uvs_rsp_if
// Valid/ready channels of the UV sphere vertex generator: grid cells in,
// vertices out.
// ----------------------------------------------------------------------------
interface uvs_req_if import uvs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [LAT_W-1:0] lat_index;
   logic [LON_W-1:0] lon_index;

   modport source (output valid, output lat_index, output lon_index, input ready);
   modport sink   (input valid, input lat_index, input lon_index, output ready);
endinterface

interface uvs_rsp_if import uvs_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic signed [COORD_W-1:0] pos_z;
   logic signed [COORD_W-1:0] norm_x;
   logic signed [COORD_W-1:0] norm_y;
   logic signed [COORD_W-1:0] norm_z;
   logic [TEX_W-1:0]          tex_u;
   logic [TEX_W-1:0]          tex_v;
   logic [2:0]                corner;
   logic                      last;

   modport source (output valid, output pos_x, output pos_y, output pos_z,
                   output norm_x, output norm_y, output norm_z, output tex_u,
                   output tex_v, output corner, output last, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                   input norm_x, input norm_y, input norm_z, input tex_u,
                   input tex_v, input corner, input last, output ready);
endinterface

FILE: rtl/uv_sphere_vertex_generator_unit.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_unit
// One UV sphere grid cell in, its six triangle vertices out.
//
// Each accepted item names a cell by latitude band and longitude segment and
// returns six vertices in the order a, b, c, c, b, d (a = (lat, lon),
// b = (lat+1, lon), c = (lat, lon+1), d = (lat+1, lon+1)), each with a
// saturated Q12.12 position, a Q12.12 normal (unit direction times radius),
// Q1.16 texture u/v, the corner slot and a last flag on the sixth vertex.
// A cell with an index at or beyond SUBDIVISIONS is taken and dropped with
// no result. A cell's six vertices leave back to back at one per cycle while
// the sink takes them; the corner sequencer feeds one vertex per cycle into
// the pipeline and takes the next cell as it issues the last corner. Each
// vertex passes the sequencer, table lookup, direction multiply, rounding,
// radius multiply, rounding and saturation, and the center add into the
// output register. A result-side stall freezes the whole pipeline in place;
// an idle sequencer still takes a new cell. The user must write the registers
// (radius, center x/y/z) only while the block is idle; this is not enforced.
// ----------------------------------------------------------------------------
`include "uv_sphere_vertex_generator_unit_assert.svh"

module uv_sphere_vertex_generator_unit
   import uvs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   uvs_req_if.sink              req_if,
   uvs_rsp_if.source            rsp_if,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata
);

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [REG_W-1:0]        radius_ff;
   logic signed [REG_W-1:0] center_x_ff, center_y_ff, center_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff   <= RADIUS_RESET;
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
      end else if (csr_we) begin
         case (csr_reg_type'(csr_index))
            REG_RADIUS:   radius_ff   <= csr_wdata;
            REG_CENTER_X: center_x_ff <= csr_wdata;
            REG_CENTER_Y: center_y_ff <= csr_wdata;
            REG_CENTER_Z: center_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline advance: everything moves unless the output holds an item
   // that the sink is not taking.
   // ------------------------------------------------------------------------
   logic vld6_ff;
   logic adv;

   assign adv = !vld6_ff || rsp_if.ready;

   // ------------------------------------------------------------------------
   // Stage 0: corner sequencer, expands one cell into six vertices
   // ------------------------------------------------------------------------
   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] lat_ff, lat_in;
   logic [IDX_W-1:0] lon_ff, lon_in;
   corner_type       corner_ff, corner_in;
   logic             seq_last;
   logic             req_fire;
   logic             req_in_range;
   logic             dlat, dlon;

   assign seq_last     = (corner_ff == CORNER_D);
   assign req_if.ready = !busy_ff || (seq_last && adv);
   assign req_fire     = req_if.valid && req_if.ready;
   assign req_in_range = (int'(req_if.lat_index) < SUBDIVISIONS) &&
                         (int'(req_if.lon_index) < SUBDIVISIONS);

   always_comb begin
      busy_in   = busy_ff;
      lat_in    = lat_ff;
      lon_in    = lon_ff;
      corner_in = corner_ff;
      if (busy_ff && adv) begin
         // step to the next corner, or finish the cell
         if (seq_last) begin
            busy_in = 1'b0;
         end else begin
            corner_in = corner_type'(corner_ff + 3'd1);
         end
      end
      if (req_fire) begin
         // out-of-range cells are taken and dropped
         busy_in   = req_in_range;
         lat_in    = IDX_W'(req_if.lat_index);
         lon_in    = IDX_W'(req_if.lon_index);
         corner_in = CORNER_A;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         corner_ff <= CORNER_A;
      end else begin
         busy_ff   <= busy_in;
         corner_ff <= corner_in;
      end
      lat_ff <= lat_in;
      lon_ff <= lon_in;
   end

   // latitude / longitude step of each corner slot
   always_comb begin
      case (corner_ff)
         CORNER_A:  begin dlat = 1'b0; dlon = 1'b0; end
         CORNER_B:  begin dlat = 1'b1; dlon = 1'b0; end
         CORNER_C:  begin dlat = 1'b0; dlon = 1'b1; end
         CORNER_C2: begin dlat = 1'b0; dlon = 1'b1; end
         CORNER_B2: begin dlat = 1'b1; dlon = 1'b0; end
         CORNER_D:  begin dlat = 1'b1; dlon = 1'b1; end
         default:   begin dlat = 1'b0; dlon = 1'b0; end
      endcase
   end

   logic [IDX_W-1:0] vert_i, vert_j;

   assign vert_i = lat_ff + IDX_W'(dlat);
   assign vert_j = lon_ff + IDX_W'(dlon);

   // ------------------------------------------------------------------------
   // Stage 1: sine/cosine and texture table lookup
   // cos(lat) = sin(i*pi/S), sin(lat) = -cos(i*pi/S), lon angle = 2j*pi/S
   // ------------------------------------------------------------------------
   logic                vld1_ff;
   logic signed [31:0]  cos_lat1_ff, sin_lat1_ff, slon1_ff, clon1_ff;
   logic [TEX_W-1:0]    u1_ff, v1_ff;
   corner_type          corner1_ff;
   logic [ANG_W-1:0]    lat_ang, lon_ang;
   logic [IDX_W-1:0]    v_idx;

   assign lat_ang = ANG_W'(vert_i);
   assign lon_ang = ANG_W'({vert_j, 1'b0});
   assign v_idx   = IDX_W'(SUBDIVISIONS) - vert_i;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= busy_ff;
      end
      if (adv) begin
         cos_lat1_ff <= TRIG_TAB[lat_ang].s;
         sin_lat1_ff <= -TRIG_TAB[lat_ang].c;
         slon1_ff    <= TRIG_TAB[lon_ang].s;
         clon1_ff    <= TRIG_TAB[lon_ang].c;
         u1_ff       <= TEX_TAB[vert_j];
         v1_ff       <= TEX_TAB[v_idx];
         corner1_ff  <= corner_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: direction products cos(lat)*cos(lon), cos(lat)*sin(lon)
   // ------------------------------------------------------------------------
   logic               vld2_ff;
   logic signed [63:0] px2_ff, pz2_ff;
   logic signed [31:0] dy2_ff;
   logic [TEX_W-1:0]   u2_ff, v2_ff;
   corner_type         corner2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else if (adv) begin
         vld2_ff <= vld1_ff;
      end
      if (adv) begin
         px2_ff     <= cos_lat1_ff * clon1_ff;
         pz2_ff     <= cos_lat1_ff * slon1_ff;
         dy2_ff     <= sin_lat1_ff;
         u2_ff      <= u1_ff;
         v2_ff      <= v1_ff;
         corner2_ff <= corner1_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: round the direction back to Q30
   // ------------------------------------------------------------------------
   logic               vld3_ff;
   logic signed [31:0] dx3_ff, dy3_ff, dz3_ff;
   logic [TEX_W-1:0]   u3_ff, v3_ff;
   corner_type         corner3_ff;
   logic signed [63:0] dx3_in, dz3_in;

   assign dx3_in = round_sh30(px2_ff);
   assign dz3_in = round_sh30(pz2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
      end else if (adv) begin
         vld3_ff <= vld2_ff;
      end
      if (adv) begin
         dx3_ff     <= dx3_in[31:0];
         dy3_ff     <= dy2_ff;
         dz3_ff     <= dz3_in[31:0];
         u3_ff      <= u2_ff;
         v3_ff      <= v2_ff;
         corner3_ff <= corner2_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 4: scale by radius (Q30 x Q4.12)
   // ------------------------------------------------------------------------
   logic               vld4_ff;
   logic signed [48:0] sx4_ff, sy4_ff, sz4_ff;
   logic [TEX_W-1:0]   u4_ff, v4_ff;
   corner_type         corner4_ff;
   logic signed [16:0] radius_s;

   assign radius_s = $signed({1'b0, radius_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         vld4_ff <= 1'b0;
      end else if (adv) begin
         vld4_ff <= vld3_ff;
      end
      if (adv) begin
         sx4_ff     <= dx3_ff * radius_s;
         sy4_ff     <= dy3_ff * radius_s;
         sz4_ff     <= dz3_ff * radius_s;
         u4_ff      <= u3_ff;
         v4_ff      <= v3_ff;
         corner4_ff <= corner3_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 5: round and saturate into the normal
   // ------------------------------------------------------------------------
   logic                      vld5_ff;
   logic signed [COORD_W-1:0] nx5_ff, ny5_ff, nz5_ff;
   logic [TEX_W-1:0]          u5_ff, v5_ff;
   corner_type                corner5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld5_ff <= 1'b0;
      end else if (adv) begin
         vld5_ff <= vld4_ff;
      end
      if (adv) begin
         nx5_ff     <= sat24(round_sh30(64'(sx4_ff)));
         ny5_ff     <= sat24(round_sh30(64'(sy4_ff)));
         nz5_ff     <= sat24(round_sh30(64'(sz4_ff)));
         u5_ff      <= u4_ff;
         v5_ff      <= v4_ff;
         corner5_ff <= corner4_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 6: add center, saturate; output register
   // ------------------------------------------------------------------------
   logic signed [COORD_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [COORD_W-1:0] nx6_ff, ny6_ff, nz6_ff;
   logic [TEX_W-1:0]          u6_ff, v6_ff;
   corner_type                corner6_ff;
   logic                      last6_ff;
   logic signed [COORD_W:0]   sum_x, sum_y, sum_z;

   assign sum_x = (COORD_W+1)'(nx5_ff) + (COORD_W+1)'(center_x_ff);
   assign sum_y = (COORD_W+1)'(ny5_ff) + (COORD_W+1)'(center_y_ff);
   assign sum_z = (COORD_W+1)'(nz5_ff) + (COORD_W+1)'(center_z_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld6_ff <= 1'b0;
      end else if (adv) begin
         vld6_ff <= vld5_ff;
      end
      if (adv) begin
         pos_x_ff   <= sat24(64'(sum_x));
         pos_y_ff   <= sat24(64'(sum_y));
         pos_z_ff   <= sat24(64'(sum_z));
         nx6_ff     <= nx5_ff;
         ny6_ff     <= ny5_ff;
         nz6_ff     <= nz5_ff;
         u6_ff      <= u5_ff;
         v6_ff      <= v5_ff;
         corner6_ff <= corner5_ff;
         last6_ff   <= (corner5_ff == CORNER_D);
      end
   end

   assign rsp_if.valid  = vld6_ff;
   assign rsp_if.pos_x  = pos_x_ff;
   assign rsp_if.pos_y  = pos_y_ff;
   assign rsp_if.pos_z  = pos_z_ff;
   assign rsp_if.norm_x = nx6_ff;
   assign rsp_if.norm_y = ny6_ff;
   assign rsp_if.norm_z = nz6_ff;
   assign rsp_if.tex_u  = u6_ff;
   assign rsp_if.tex_v  = v6_ff;
   assign rsp_if.corner = corner6_ff;
   assign rsp_if.last   = last6_ff;

   // ------------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------------
   `UVS_ASSERT_NEXT(a_accept_starts_cell, req_fire && req_in_range,
                    busy_ff && corner_ff == CORNER_A)
   `UVS_ASSERT_NEXT(a_corner_steps, busy_ff && adv && !seq_last,
                    busy_ff && corner_ff == corner_type'($past(corner_ff) + 3'd1))
   `UVS_ASSERT_NEXT(a_stall_keeps_output, vld6_ff && !rsp_if.ready, vld6_ff)
   `UVS_ASSERT_IMPL(a_last_on_corner_d, vld6_ff, last6_ff == (corner6_ff == CORNER_D))

endmodule
